FILE: design/pclip_pkg.sv
// Package: widths, codes and control/status types of the polygon plane clipper.
`default_nettype none
package pclip_pkg;

    localparam int POS_W  = 32;                 // Q16.16 coordinate
    localparam int NRM_W  = 16;                 // Q2.14 normal component
    localparam int DIST_W = 50;                 // signed plane distance, |d| < 2^48
    localparam int DEN_W  = 50;                 // |dP - dC| < 2^49
    localparam int REM_W  = DEN_W + 1;          // divider partial remainder
    localparam int T_W    = 32;                 // crossing parameter, 31 fraction bits
    localparam int T_FRAC = T_W - 1;
    localparam int DEL_W  = POS_W + 1;          // coordinate difference
    localparam int MAG_W  = DEL_W + T_W;        // |delta| * t
    localparam int STP_W  = MAG_W - T_FRAC;     // rounded step
    localparam int DATA_W = 3 * POS_W + 3 * NRM_W;
    localparam int CFG_AW = 8;
    localparam int CFG_DW = 32;
    localparam int CNT_W  = 5;
    localparam int DIV_STEPS = T_W;

    localparam logic [CFG_AW-1:0] CFG_NORMAL_X = 8'd0;
    localparam logic [CFG_AW-1:0] CFG_NORMAL_Y = 8'd1;
    localparam logic [CFG_AW-1:0] CFG_NORMAL_Z = 8'd2;
    localparam logic [CFG_AW-1:0] CFG_OFFSET   = 8'd3;

    localparam logic signed [NRM_W-1:0] NORMAL_Z_RESET = 16'sd16384;

    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic signed [NRM_W-1:0]  t_nrm;
    typedef logic signed [DIST_W-1:0] t_dist;

    // controller -> datapath
    typedef struct packed {
        logic       load;         // take the accepted vertex
        logic       dist_step;    // one multiply-accumulate of the distance
        logic [1:0] idx;          // component / coordinate index
        logic       store_first;  // remember the vertex as the polygon's first
        logic       div_load;     // start the crossing divide
        logic       div_step;     // one restoring divide step
        logic       mul_step;     // interpolation pipeline slot
        logic       stage_x;      // queue the crossing point
        logic       stage_c;      // queue the edge end vertex
        logic       finish;       // close the item
        logic       closing;      // edge operands: last -> first
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic have_first;
        logic fin;
        logic p_in;
        logic c_in;
        logic out_free;
        logic pend_valid;
    } t_sts;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_DIST      = 10'b00_0000_0010,
        S_CHK       = 10'b00_0000_0100,
        S_EDGE      = 10'b00_0000_1000,
        S_DIV       = 10'b00_0001_0000,
        S_MUL       = 10'b00_0010_0000,
        S_EMIT_X    = 10'b00_0100_0000,
        S_EMIT_C    = 10'b00_1000_0000,
        S_EDGE_DONE = 10'b01_0000_0000,
        S_FINISH    = 10'b10_0000_0000
    } t_state;

endpackage
`default_nettype wire

FILE: design/pclip_ctrl.sv
// Controller: sequences distance, edge tests, divide, interpolation and result staging.
`default_nettype none
module pclip_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire pclip_pkg::t_sts i_sts,
    output pclip_pkg::t_cmd      o_cmd
);
    import pclip_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_closing, n_closing;
    logic             w_can_stage;

    assign w_can_stage = !i_sts.pend_valid || i_sts.out_free;
    assign o_s_tready  = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_closing = r_closing;
        o_cmd     = '0;
        o_cmd.idx = r_cnt[1:0];
        o_cmd.closing = r_closing;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_closing  = 1'b0;
                    n_state    = S_DIST;
                end
            end
            S_DIST: begin
                o_cmd.dist_step = 1'b1;
                if (r_cnt == CNT_W'(2)) begin
                    n_state = S_CHK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CHK: begin
                if (!i_sts.have_first) begin
                    o_cmd.store_first = 1'b1;
                    if (i_sts.fin) begin
                        n_closing = 1'b1;
                        n_state   = S_EDGE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (i_sts.p_in && i_sts.c_in) begin
                    n_state = S_EMIT_C;
                end else if (i_sts.p_in != i_sts.c_in) begin
                    o_cmd.div_load = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_EDGE_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(3)) begin
                    n_state = S_EMIT_X;
                end
            end
            S_EMIT_X: begin
                if (w_can_stage) begin
                    o_cmd.stage_x = 1'b1;
                    n_state = i_sts.c_in ? S_EMIT_C : S_EDGE_DONE;
                end
            end
            S_EMIT_C: begin
                if (w_can_stage) begin
                    o_cmd.stage_c = 1'b1;
                    n_state = S_EDGE_DONE;
                end
            end
            S_EDGE_DONE: begin
                if (!r_closing && i_sts.fin) begin
                    n_closing = 1'b1;
                    n_state   = S_EDGE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_closing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_closing <= n_closing;
        end
    end

endmodule
`default_nettype wire

FILE: design/pclip_dp.sv
// Datapath: plane registers, vertex state, distance MAC, divider, interpolator, output.
`default_nettype none
module pclip_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [pclip_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [pclip_pkg::CFG_DW-1:0]  i_cfg_data,
    input  wire logic [pclip_pkg::DATA_W-1:0]  i_s_tdata,
    input  wire logic                          i_s_tlast,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [pclip_pkg::DATA_W-1:0]       o_m_tdata,
    output logic                               o_m_tlast,
    output logic                               o_m_tuser,
    input  wire pclip_pkg::t_cmd               i_cmd,
    output pclip_pkg::t_sts                    o_sts
);
    import pclip_pkg::*;

    // plane
    t_nrm r_nx, r_ny, r_nz;
    logic signed [CFG_DW-1:0] r_off;

    // vertex state
    t_pos  r_cur_pos [3];
    t_nrm  r_cur_nrm [3];
    t_dist r_cur_d;
    logic  r_fin;
    t_pos  r_first_pos [3];
    t_nrm  r_first_nrm [3];
    t_dist r_first_d;
    t_pos  r_prev_pos [3];
    t_dist r_prev_d;
    logic  r_have_first, r_emitted;

    // divider and interpolator
    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [T_W-1:0]   r_q;
    logic [MAG_W-1:0] r_mag;
    logic             r_neg;
    t_pos             r_base;
    t_pos             r_x [3];

    // one result held back so polygon_end can be set on the true last one
    t_pos r_pend_pos [3];
    t_nrm r_pend_nrm [3];
    logic r_pend_v;

    logic              r_out_v, r_out_last, r_out_empty;
    logic [DATA_W-1:0] r_out_data;

    // edge operands
    t_pos  w_p_pos [3];
    t_pos  w_c_pos [3];
    t_nrm  w_c_nrm [3];
    t_dist w_pd, w_cd;
    logic [DIST_W:0]   w_dd;
    logic [DEN_W-1:0]  w_num, w_den;
    logic              w_trial;
    logic [REM_W-1:0]  w_rem_sub;
    logic [1:0]        w_k, w_km1;
    logic signed [NRM_W-1:0] w_nk;
    t_pos              w_pk;
    logic signed [2*CFG_DW-1:0] w_prod_full;
    t_dist             w_prod;
    logic signed [DEL_W-1:0] w_delta;
    logic [DEL_W-1:0]  w_dmag;
    logic [MAG_W-1:0]  w_mag_r;
    logic [STP_W-1:0]  w_step, w_xs;
    logic              w_out_free, w_stage, w_push_pend;
    logic [DATA_W-1:0] w_pend_data;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_p_pos[j] = i_cmd.closing ? r_cur_pos[j]   : r_prev_pos[j];
            w_c_pos[j] = i_cmd.closing ? r_first_pos[j] : r_cur_pos[j];
            w_c_nrm[j] = i_cmd.closing ? r_first_nrm[j] : r_cur_nrm[j];
        end
        w_pd = i_cmd.closing ? r_cur_d   : r_prev_d;
        w_cd = i_cmd.closing ? r_first_d : r_cur_d;
    end

    assign w_dd  = {w_pd[DIST_W-1], w_pd} - {w_cd[DIST_W-1], w_cd};
    assign w_num = w_pd[DIST_W-1] ? DEN_W'(-w_pd) : DEN_W'(w_pd);
    assign w_den = w_dd[DIST_W] ? DEN_W'(-w_dd) : DEN_W'(w_dd);

    assign w_trial   = r_rem >= {1'b0, r_den};
    assign w_rem_sub = w_trial ? (r_rem - {1'b0, r_den}) : r_rem;

    // component select for the distance MAC and the interpolator
    assign w_k   = (i_cmd.idx == 2'd3) ? 2'd0 : i_cmd.idx;
    assign w_km1 = i_cmd.idx - 2'd1;
    always_comb begin
        unique case (w_k)
            2'd0:    w_nk = r_nx;
            2'd1:    w_nk = r_ny;
            default: w_nk = r_nz;
        endcase
    end
    assign w_pk        = r_cur_pos[w_k];
    assign w_prod_full = 64'(w_nk * w_pk);
    assign w_prod      = DIST_W'(w_prod_full);

    assign w_delta = {w_c_pos[w_k][POS_W-1], w_c_pos[w_k]}
                   - {w_p_pos[w_k][POS_W-1], w_p_pos[w_k]};
    assign w_dmag  = w_delta[DEL_W-1] ? DEL_W'(-w_delta) : DEL_W'(w_delta);
    assign w_mag_r = r_mag + (MAG_W'(1) << (T_FRAC - 1));
    assign w_step  = w_mag_r[MAG_W-1:T_FRAC];
    assign w_xs    = r_neg ? (STP_W'(r_base) - w_step) : (STP_W'(r_base) + w_step);

    assign w_out_free  = !r_out_v || i_m_tready;
    assign w_stage     = i_cmd.stage_x || i_cmd.stage_c;
    assign w_push_pend = r_pend_v && (w_stage || i_cmd.finish);
    assign w_pend_data = {r_pend_nrm[2], r_pend_nrm[1], r_pend_nrm[0],
                          r_pend_pos[2], r_pend_pos[1], r_pend_pos[0]};

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx  <= '0;
            r_ny  <= '0;
            r_nz  <= NORMAL_Z_RESET;
            r_off <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_NORMAL_X: r_nx  <= i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Y: r_ny  <= i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Z: r_nz  <= i_cfg_data[NRM_W-1:0];
                CFG_OFFSET:   r_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vertex payload and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int j = 0; j < 3; j++) begin
                r_cur_pos[j] <= i_s_tdata[j*POS_W +: POS_W];
                r_cur_nrm[j] <= i_s_tdata[3*POS_W + j*NRM_W +: NRM_W];
            end
            r_fin   <= i_s_tlast;
            r_cur_d <= {{(DIST_W-CFG_DW-14){r_off[CFG_DW-1]}}, r_off, 14'd0};
        end
        if (i_cmd.dist_step) begin
            r_cur_d <= r_cur_d + w_prod;
        end
        if (i_cmd.store_first) begin
            r_first_pos <= r_cur_pos;
            r_first_nrm <= r_cur_nrm;
            r_first_d   <= r_cur_d;
        end
        if (i_cmd.div_load) begin
            r_rem <= REM_W'(w_num);
            r_den <= w_den;
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= {w_rem_sub[REM_W-2:0], 1'b0};
            r_q   <= {r_q[T_W-2:0], w_trial};
        end
        if (i_cmd.mul_step) begin
            if (i_cmd.idx != 2'd3) begin
                r_mag  <= MAG_W'(w_dmag * r_q);
                r_neg  <= w_delta[DEL_W-1];
                r_base <= w_p_pos[w_k];
            end
            if (i_cmd.idx != 2'd0) begin
                r_x[w_km1] <= w_xs[POS_W-1:0];
            end
        end
        if (w_stage) begin
            r_pend_pos <= i_cmd.stage_x ? r_x : w_c_pos;
            r_pend_nrm <= w_c_nrm;
        end
        if (i_cmd.finish) begin
            r_prev_pos <= r_cur_pos;
            r_prev_d   <= r_cur_d;
        end
    end

    // control flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_emitted    <= 1'b0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cmd.store_first) begin
                r_have_first <= 1'b1;
            end
            if (w_stage) begin
                r_pend_v <= 1'b1;
            end
            if (w_push_pend || (i_cmd.finish && r_fin && !r_emitted)) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
                if (r_fin) begin
                    r_have_first <= 1'b0;
                    r_emitted    <= 1'b0;
                end else if (r_pend_v) begin
                    r_emitted <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_pend) begin
            r_out_data  <= w_pend_data;
            r_out_last  <= i_cmd.finish && r_fin;
            r_out_empty <= 1'b0;
        end else if (i_cmd.finish && r_fin && !r_emitted) begin
            r_out_data  <= '0;
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_empty;

    assign o_sts.have_first = r_have_first;
    assign o_sts.fin        = r_fin;
    assign o_sts.p_in       = w_pd[DIST_W-1] || (w_pd == '0);
    assign o_sts.c_in       = w_cd[DIST_W-1] || (w_cd == '0);
    assign o_sts.out_free   = w_out_free;
    assign o_sts.pend_valid = r_pend_v;

endmodule
`default_nettype wire

FILE: design/polygon_plane_clipper.sv
// Top level: one-plane Sutherland-Hodgman polygon clipper, controller plus datapath.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------------
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_addr (register), i_cfg_data
//  s (vtx)  | in        | i_s_tvalid / o_s_tready   | i_s_tdata (pos, normal), i_s_tlast
//  m (out)  | out       | o_m_tvalid / i_m_tready   | o_m_tdata, o_m_tlast, o_m_tuser
//
// One vertex item at a time. An item is accepted and takes three distance steps, a check
// and a finish, plus an edge test and a close-out step for each edge tested, one staging
// step for each result, and 32 restoring divide steps and 4 interpolation steps for each
// edge that crosses the plane.
// Each staged result waits for a free output register when the sink stalls; a new vertex
// is taken while a result waits. Synchronous active-low reset restores the plane to z = +1.
`default_nettype none
module polygon_plane_clipper (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pclip_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [pclip_pkg::CFG_DW-1:0]        i_cfg_data,
    // vertex items in
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // low to high: pos_x[31:0] pos_y[63:32] pos_z[95:64]
    //              norm_x[111:96] norm_y[127:112] norm_z[143:128]
    input  wire logic [pclip_pkg::DATA_W-1:0]        i_s_tdata,
    input  wire logic                                i_s_tlast,    // final_vertex
    // clipped vertex items out
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // low to high: out_x[31:0] out_y[63:32] out_z[95:64]
    //              out_norm_x[111:96] out_norm_y[127:112] out_norm_z[143:128]
    output logic [pclip_pkg::DATA_W-1:0]             o_m_tdata,
    output logic                                     o_m_tlast,    // polygon_end
    output logic                                     o_m_tuser     // empty_polygon
);
    import pclip_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // plane registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    pclip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pclip_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule
`default_nettype wire

FILE: design/pclip_chk.sv
// Checker: port-level properties of the clipper, bound to the top level.
`default_nettype none
module pclip_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [pclip_pkg::DATA_W-1:0]   o_m_tdata,
    input wire logic                           o_m_tlast,
    input wire logic                           o_m_tuser
);
    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // the empty marker closes the polygon and carries zero fields
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && (o_m_tdata == '0))
        else $error("malformed empty marker");

    // a vertex is worked on alone: no new vertex right after one is taken
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("vertex taken while busy");

    // reset drops any result
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind polygon_plane_clipper pclip_chk u_pclip_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
